// ----- hw/rtl/pisq_pkg.sv -----
// Shared types and constants for the positional insert sequence store.
`default_nettype none
package pisq_pkg;

  localparam int DEPTH  = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 6;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    STATUS_ELEMENT = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_ROT_DN = 2'd2,
    CELL_ROT_UP = 2'd3
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_FWD  = 2'd1,
    ST_REV  = 2'd2
  } ctrl_state_t;

  typedef struct packed {
    cell_op_t                  op;
    logic [POS_W-1:0]          pos;
    logic [CNT_W-1:0]          count;
    logic signed [DATA_W-1:0]  value;
  } cell_cmd_t;

endpackage : pisq_pkg
`default_nettype wire

// ----- hw/rtl/positional_insert_sequence_store_core.sv -----
// Top level: a ring of DEPTH value cells driven by the insert/readout sequencer.
// A rejected word is valid the cycle after acceptance; an insert first shifts the
// cells, then its 2*n words (n = count after insert) leave the chain through the
// output register, one per cycle unless stalled, while the input is held off.
// A rejected input yields one word; inputs then follow one per cycle unless stalled.
// Reset clears the sequencer, fill count and output valid; cell contents are not reset.
`default_nettype none
module positional_insert_sequence_store_core
  import pisq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [5:0] position, [37:6] value, [39:38] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] element
  output logic [2:0]       out_tuser,  // [1:0] status, [2] reverse_pass
  output logic             out_tlast
);

  logic signed [DATA_W-1:0] cell_data [DEPTH];
  cell_cmd_t                cmd;
  status_t                  out_status;
  logic                     out_rev;
  logic signed [DATA_W-1:0] out_elem;

  pisq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_pos     (in_tdata[POS_W-1:0]),
    .in_value   (in_tdata[POS_W+DATA_W-1:POS_W]),
    .head_data  (cell_data[0]),
    .tail_data  (cell_data[DEPTH-1]),
    .cmd        (cmd),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_status),
    .out_rev    (out_rev),
    .out_elem   (out_elem),
    .out_last   (out_tlast)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] lo_d, hi_d;
    if (i == 0) begin : g_lo_wrap
      assign lo_d = cell_data[DEPTH-1];
    end else begin : g_lo
      assign lo_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi_wrap
      assign hi_d = cell_data[0];
    end else begin : g_hi
      assign hi_d = cell_data[i+1];
    end
    pisq_cell u_cell (
      .clk      (clk),
      .cell_idx (IDX_W'(i)),
      .cmd      (cmd),
      .lo_data  (lo_d),
      .hi_data  (hi_d),
      .data     (cell_data[i])
    );
  end

  assign out_tdata = out_elem;
  assign out_tuser = {out_rev, out_status};

endmodule : positional_insert_sequence_store_core
`default_nettype wire

// ----- hw/rtl/pisq_cell.sv -----
// One storage cell of the entry chain: holds one value, shifts on insert, rotates on readout.
`default_nettype none
module pisq_cell
  import pisq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic [IDX_W-1:0]         cell_idx,
  input  wire cell_cmd_t                cmd,
  input  wire logic signed [DATA_W-1:0] lo_data,
  input  wire logic signed [DATA_W-1:0] hi_data,
  output logic signed [DATA_W-1:0]      data
);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;
  logic [POS_W-1:0]         my_pos;

  assign my_pos = POS_W'(cell_idx);

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      CELL_HOLD:   data_nxt = data_r;
      CELL_INSERT: begin
        if (my_pos == cmd.pos) begin
          data_nxt = cmd.value;
        end else if (my_pos > cmd.pos && my_pos <= POS_W'(cmd.count)) begin
          // make room: take the entry from below
          data_nxt = lo_data;
        end
      end
      CELL_ROT_DN: data_nxt = hi_data;
      CELL_ROT_UP: data_nxt = lo_data;
      default:     data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule : pisq_cell
`default_nettype wire

// ----- hw/rtl/pisq_ctrl.sv -----
// Sequencer: checks inserts, steers the cell chain and drives the output register.
`default_nettype none
module pisq_ctrl
  import pisq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [POS_W-1:0]         in_pos,
  input  wire logic signed [DATA_W-1:0] in_value,
  input  wire logic signed [DATA_W-1:0] head_data,
  input  wire logic signed [DATA_W-1:0] tail_data,
  output cell_cmd_t                     cmd,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output status_t                       out_status,
  output logic                          out_rev,
  output logic signed [DATA_W-1:0]      out_elem,
  output logic                          out_last
);

  ctrl_state_t              state_r, state_nxt;
  logic [CNT_W-1:0]         fill_r, fill_nxt;
  logic [CNT_W-1:0]         idx_r, idx_nxt;
  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic                     out_rev_r, out_rev_nxt;
  logic signed [DATA_W-1:0] out_elem_r, out_elem_nxt;
  logic                     out_last_r, out_last_nxt;
  logic                     slot_free, accept, pos_bad, is_full, idx_end, load_out;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign pos_bad   = in_pos > POS_W'(fill_r);
  assign is_full   = fill_r == CNT_W'(DEPTH);
  assign idx_end   = idx_r == (fill_r - CNT_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept && !pos_bad && !is_full) state_nxt = ST_FWD;
      ST_FWD:  if (slot_free && idx_end) state_nxt = ST_REV;
      ST_REV:  if (slot_free && idx_end) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs, chain command and counters
  always_comb begin
    cmd            = '{op: CELL_HOLD, pos: in_pos, count: fill_r, value: in_value};
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    load_out       = 1'b0;
    out_status_nxt = out_status_r;
    out_rev_nxt    = out_rev_r;
    out_elem_nxt   = out_elem_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (pos_bad || is_full) begin
            load_out       = 1'b1;
            out_status_nxt = pos_bad ? STATUS_INVALID : STATUS_FULL;
            out_rev_nxt    = 1'b0;
            out_elem_nxt   = '0;
            out_last_nxt   = 1'b1;
          end else begin
            cmd.op   = CELL_INSERT;
            fill_nxt = fill_r + CNT_W'(1);
            idx_nxt  = '0;
          end
        end
      end
      ST_FWD: begin
        if (slot_free) begin
          // emit head, rotate the whole ring down one place
          cmd.op         = CELL_ROT_DN;
          load_out       = 1'b1;
          out_status_nxt = STATUS_ELEMENT;
          out_rev_nxt    = 1'b0;
          out_elem_nxt   = head_data;
          out_last_nxt   = 1'b0;
          idx_nxt        = idx_end ? '0 : idx_r + CNT_W'(1);
        end
      end
      ST_REV: begin
        if (slot_free) begin
          // emit the ring tail and rotate back up; ends with the ring restored
          cmd.op         = CELL_ROT_UP;
          load_out       = 1'b1;
          out_status_nxt = STATUS_ELEMENT;
          out_rev_nxt    = 1'b1;
          out_elem_nxt   = tail_data;
          out_last_nxt   = idx_end;
          idx_nxt        = idx_end ? '0 : idx_r + CNT_W'(1);
        end
      end
      default: cmd.op = CELL_HOLD;
    endcase
    out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_rev_r    <= out_rev_nxt;
    out_elem_r   <= out_elem_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_rev    = out_rev_r;
  assign out_elem   = out_elem_r;
  assign out_last   = out_last_r;

endmodule : pisq_ctrl
`default_nettype wire
